FILE: rtl/core/dpwc_pkg.sv
// ----------------------------------------------------------------------------
// dpwc_pkg
// Shared widths, register codes and types of the clamped PID controller.
// ----------------------------------------------------------------------------
package dpwc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  // Five products are added, so three guard bits cover the growth.
  localparam int SUM_BITS       = PROD_BITS + 3;
  localparam int SHIFT_BITS     = SUM_BITS - COEF_FRAC_BITS;

  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 5;
  localparam int REG_IDX_BITS   = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_COEF_E0    = 3'd0,
    REG_COEF_E1    = 3'd1,
    REG_COEF_E2    = 3'd2,
    REG_COEF_U1    = 3'd3,
    REG_COEF_U2    = 3'd4,
    REG_CLAMP_HIGH = 3'd5,
    REG_CLAMP_LOW  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0]   coef_e0;
    logic signed [COEF_BITS-1:0]   coef_e1;
    logic signed [COEF_BITS-1:0]   coef_e2;
    logic signed [COEF_BITS-1:0]   coef_u1;
    logic signed [COEF_BITS-1:0]   coef_u2;
    logic signed [SAMPLE_BITS-1:0] clamp_high;
    logic signed [SAMPLE_BITS-1:0] clamp_low;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] err;
    logic signed [SAMPLE_BITS-1:0] err_prev1;
    logic signed [SAMPLE_BITS-1:0] err_prev2;
    logic signed [SAMPLE_BITS-1:0] out_prev1;
    logic signed [SAMPLE_BITS-1:0] out_prev2;
  } hist_t;

endpackage

FILE: rtl/core/dpwc_regs.sv
// ----------------------------------------------------------------------------
// dpwc_regs
// APB register file holding the filter coefficients and the output limits.
// ----------------------------------------------------------------------------
module dpwc_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [dpwc_pkg::APB_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [dpwc_pkg::APB_DATA_BITS-1:0]   cfg_pwdata,
  output logic [dpwc_pkg::APB_DATA_BITS-1:0]   cfg_prdata,
  output logic                                 cfg_pready,
  output dpwc_pkg::cfg_t                       cfg_o
);

  dpwc_pkg::cfg_t                          cfg_r;
  dpwc_pkg::cfg_t                          cfg_nxt;
  logic                                    wr_en;
  logic [dpwc_pkg::REG_IDX_BITS-1:0]       idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[dpwc_pkg::APB_ADDR_BITS-1:2];
  assign cfg_o      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        dpwc_pkg::REG_COEF_E0:
          cfg_nxt.coef_e0 = cfg_pwdata[dpwc_pkg::COEF_BITS-1:0];
        dpwc_pkg::REG_COEF_E1:
          cfg_nxt.coef_e1 = cfg_pwdata[dpwc_pkg::COEF_BITS-1:0];
        dpwc_pkg::REG_COEF_E2:
          cfg_nxt.coef_e2 = cfg_pwdata[dpwc_pkg::COEF_BITS-1:0];
        dpwc_pkg::REG_COEF_U1:
          cfg_nxt.coef_u1 = cfg_pwdata[dpwc_pkg::COEF_BITS-1:0];
        dpwc_pkg::REG_COEF_U2:
          cfg_nxt.coef_u2 = cfg_pwdata[dpwc_pkg::COEF_BITS-1:0];
        dpwc_pkg::REG_CLAMP_HIGH:
          cfg_nxt.clamp_high = cfg_pwdata[dpwc_pkg::SAMPLE_BITS-1:0];
        dpwc_pkg::REG_CLAMP_LOW:
          cfg_nxt.clamp_low = cfg_pwdata[dpwc_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the register sign-extended to the bus width.
  always_comb begin
    unique case (idx)
      dpwc_pkg::REG_COEF_E0:    cfg_prdata = dpwc_pkg::APB_DATA_BITS'(cfg_r.coef_e0);
      dpwc_pkg::REG_COEF_E1:    cfg_prdata = dpwc_pkg::APB_DATA_BITS'(cfg_r.coef_e1);
      dpwc_pkg::REG_COEF_E2:    cfg_prdata = dpwc_pkg::APB_DATA_BITS'(cfg_r.coef_e2);
      dpwc_pkg::REG_COEF_U1:    cfg_prdata = dpwc_pkg::APB_DATA_BITS'(cfg_r.coef_u1);
      dpwc_pkg::REG_COEF_U2:    cfg_prdata = dpwc_pkg::APB_DATA_BITS'(cfg_r.coef_u2);
      dpwc_pkg::REG_CLAMP_HIGH: cfg_prdata = dpwc_pkg::APB_DATA_BITS'(cfg_r.clamp_high);
      dpwc_pkg::REG_CLAMP_LOW:  cfg_prdata = dpwc_pkg::APB_DATA_BITS'(cfg_r.clamp_low);
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_e0    <= '0;
      cfg_r.coef_e1    <= '0;
      cfg_r.coef_e2    <= '0;
      cfg_r.coef_u1    <= '0;
      cfg_r.coef_u2    <= '0;
      cfg_r.clamp_high <= {1'b0, {(dpwc_pkg::SAMPLE_BITS-1){1'b1}}};
      cfg_r.clamp_low  <= {1'b1, {(dpwc_pkg::SAMPLE_BITS-1){1'b0}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/dpwc_calc.sv
// ----------------------------------------------------------------------------
// dpwc_calc
// Five products, their signed sum, the floor shift and the output clamp.
// ----------------------------------------------------------------------------
module dpwc_calc (
  input  dpwc_pkg::cfg_t                        cfg_i,
  input  dpwc_pkg::hist_t                       hist_i,
  output logic [dpwc_pkg::SAMPLE_BITS-1:0]      drive_o
);

  logic signed [dpwc_pkg::PROD_BITS-1:0]   p_e0;
  logic signed [dpwc_pkg::PROD_BITS-1:0]   p_e1;
  logic signed [dpwc_pkg::PROD_BITS-1:0]   p_e2;
  logic signed [dpwc_pkg::PROD_BITS-1:0]   p_u1;
  logic signed [dpwc_pkg::PROD_BITS-1:0]   p_u2;
  logic signed [dpwc_pkg::SUM_BITS-1:0]    sum;
  logic signed [dpwc_pkg::SHIFT_BITS-1:0]  shifted;
  logic signed [dpwc_pkg::SHIFT_BITS-1:0]  hi_ext;
  logic signed [dpwc_pkg::SHIFT_BITS-1:0]  lo_ext;

  assign p_e0 = cfg_i.coef_e0 * hist_i.err;
  assign p_e1 = cfg_i.coef_e1 * hist_i.err_prev1;
  assign p_e2 = cfg_i.coef_e2 * hist_i.err_prev2;
  assign p_u1 = cfg_i.coef_u1 * hist_i.out_prev1;
  assign p_u2 = cfg_i.coef_u2 * hist_i.out_prev2;

  assign sum = dpwc_pkg::SUM_BITS'(p_e0) + dpwc_pkg::SUM_BITS'(p_e1)
             + dpwc_pkg::SUM_BITS'(p_e2) - dpwc_pkg::SUM_BITS'(p_u1)
             - dpwc_pkg::SUM_BITS'(p_u2);

  // Dropping the fraction bits of a two's complement value rounds to minus infinity.
  assign shifted = sum[dpwc_pkg::SUM_BITS-1:dpwc_pkg::COEF_FRAC_BITS];
  assign hi_ext  = dpwc_pkg::SHIFT_BITS'(cfg_i.clamp_high);
  assign lo_ext  = dpwc_pkg::SHIFT_BITS'(cfg_i.clamp_low);

  // With inverted limits, the high limit wins only above it; else the low one.
  always_comb begin
    if (shifted > hi_ext) begin
      drive_o = cfg_i.clamp_high;
    end else if (shifted < lo_ext) begin
      drive_o = cfg_i.clamp_low;
    end else begin
      drive_o = shifted[dpwc_pkg::SAMPLE_BITS-1:0];
    end
  end

endmodule

FILE: rtl/core/discrete_pid_with_clamp_unit.sv
// ----------------------------------------------------------------------------
// discrete_pid_with_clamp_unit
// Second-order PID difference equation with a filtered derivative, followed
// by a clamp to programmable limits; one drive value per error sample.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_stall  | in_error_sample (16b signed)
//   out     | output    | out_valid / out_stall| out_drive (16b signed)
//   cfg     | input     | APB write, pready=1  | seven coefficient/limit regs
//
// An item is held in the input register and is then computed in a single
// pass into the result register, so one item may be accepted every cycle
// while the output does not stall. The limit is the feedback path: the next
// item needs the clamped drive of this one, which is a combinational path
// through the five multipliers, the adder and the clamp.
// Reset is synchronous and active low; it clears the histories, the valid
// flags and the cfg registers (limits go to the full 16-bit range).
// A stalled result holds in the result register while the input register
// still takes one more item, so the input side stalls only when both are full.
// ----------------------------------------------------------------------------
module discrete_pid_with_clamp_unit (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dpwc_pkg::SAMPLE_BITS-1:0]    in_error_sample,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dpwc_pkg::SAMPLE_BITS-1:0]    out_drive,

  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [dpwc_pkg::APB_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [dpwc_pkg::APB_DATA_BITS-1:0]  cfg_pwdata,
  output logic [dpwc_pkg::APB_DATA_BITS-1:0]  cfg_prdata,
  output logic                                cfg_pready
);

  dpwc_pkg::cfg_t                      cfg;
  dpwc_pkg::hist_t                     hist;

  // Input register stage.
  logic                                in_valid_r;
  logic                                in_valid_nxt;
  logic [dpwc_pkg::SAMPLE_BITS-1:0]    err_r;

  // Result register stage.
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic [dpwc_pkg::SAMPLE_BITS-1:0]    drive_r;
  logic [dpwc_pkg::SAMPLE_BITS-1:0]    drive_calc;

  // Error and output histories of the difference equation.
  logic [dpwc_pkg::SAMPLE_BITS-1:0]    err_prev1_r;
  logic [dpwc_pkg::SAMPLE_BITS-1:0]    err_prev2_r;
  logic [dpwc_pkg::SAMPLE_BITS-1:0]    out_prev1_r;
  logic [dpwc_pkg::SAMPLE_BITS-1:0]    out_prev2_r;

  logic                                accept;
  logic                                fire;

  dpwc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  assign hist.err       = err_r;
  assign hist.err_prev1 = err_prev1_r;
  assign hist.err_prev2 = err_prev2_r;
  assign hist.out_prev1 = out_prev1_r;
  assign hist.out_prev2 = out_prev2_r;

  dpwc_calc u_calc (
    .cfg_i   (cfg),
    .hist_i  (hist),
    .drive_o (drive_calc)
  );

  // The held item is computed whenever the result register is free or is
  // being emptied in this cycle.
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  assign in_valid_nxt  = accept || (in_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_drive = drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      err_prev1_r <= '0;
      err_prev2_r <= '0;
      out_prev1_r <= '0;
      out_prev2_r <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // The histories move on with every computed item.
      if (fire) begin
        err_prev1_r <= err_r;
        err_prev2_r <= err_prev1_r;
        out_prev1_r <= drive_calc;
        out_prev2_r <= out_prev1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r <= in_error_sample;
    end
    if (fire) begin
      drive_r <= drive_calc;
    end
  end

endmodule
